### sv/llfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llfp_pkg
// Shared item types and codes for the log line field parser.
// ----------------------------------------------------------------------------
package llfp_pkg;

  // Level codes carried in a result item
  localparam logic [3:0] LVL_FATAL    = 4'd0;
  localparam logic [3:0] LVL_CRITICAL = 4'd1;
  localparam logic [3:0] LVL_ERROR    = 4'd2;
  localparam logic [3:0] LVL_WARNING  = 4'd3;
  localparam logic [3:0] LVL_INFO     = 4'd4;
  localparam logic [3:0] LVL_DEBUG    = 4'd5;
  localparam logic [3:0] LVL_TRACE    = 4'd6;
  localparam logic [3:0] LVL_STATUS   = 4'd7;
  localparam logic [3:0] LVL_UNKNOWN  = 4'd8;
  localparam logic [3:0] LVL_CONT     = 4'd9;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_data;
  } llfp_in_t;

  typedef struct packed {
    logic [3:0]  level;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [63:0] thread_id;
    logic [31:0] component_start;
    logic [31:0] component_length;
    logic [31:0] text_start;
    logic [31:0] text_length;
  } llfp_out_t;

endpackage

### sv/log_line_field_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_line_field_parser
// Splits streamed log text into per-line date, level, component, thread and
// message records.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_item carry one text byte per item, or an
//   end-of-data marker that flushes the open line and restarts the parser.
//   out_valid/out_ready/out_item carry at most one record per input item:
//   a message record, or a continuation record (level 9) for a line that
//   never reached its message text.
//   Flow: an accepted item waits in the input register until the result
//   register can take a record; it is then parsed out of the input register
//   and its record, if any, lands in the result register, raising out_valid.
//   Throughput: one item per cycle while no record is stalled in the result
//   register; the per-byte update is a phase step and a small constant
//   multiply-add, done in a single pass between registers. Items that produce
//   no record (skipped line ends, field bytes) pass through the same way.
//   Stall: while a record waits in the result register with out_ready low,
//   the input register holds its item and in_ready drops once it is full.
//   Reset (rst_n low, synchronous): parse state returns to the start of a
//   line at byte position zero, level unknown, and both registers empty.
// ----------------------------------------------------------------------------
module log_line_field_parser #(
  parameter int POSITION_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  llfp_pkg::llfp_in_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output llfp_pkg::llfp_out_t out_item
);
  import llfp_pkg::*;

  logic      in_valid_r;
  llfp_in_t  in_item_r;
  logic      slot_free;
  logic      advance;
  logic      rec_valid;
  llfp_out_t rec;

  // advance the held item once the result register can take its record
  assign advance  = in_valid_r && slot_free;
  assign in_ready = !in_valid_r || advance;

  // input register: hold the item until the parser consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  llfp_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .item     (in_item_r),
    .rec_valid(rec_valid),
    .rec      (rec)
  );

  // load only when this item produces a record; otherwise drain on out_ready
  llfp_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance && rec_valid),
    .din      (rec),
    .slot_free(slot_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

### sv/llfp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llfp_core
// Per-line parse state and the single-pass byte update that forms records.
// ----------------------------------------------------------------------------
module llfp_core #(
  parameter int POSITION_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  llfp_pkg::llfp_in_t  item,
  output logic                rec_valid,
  output llfp_pkg::llfp_out_t rec
);
  import llfp_pkg::*;

  localparam int PB = POSITION_BITS;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LC    = 8'h63;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF_LO = 8'h66;
  localparam logic [7:0] CH_LI    = 8'h69;
  localparam logic [7:0] CH_LS    = 8'h73;
  localparam logic [7:0] CH_LT    = 8'h74;
  localparam logic [7:0] CH_LW    = 8'h77;

  typedef enum logic [3:0] {
    PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND, PH_LEVEL,
    PH_LEVEL_SKIP, PH_COMPONENT, PH_COMPONENT_SKIP, PH_THREAD, PH_MESSAGE,
    PH_CONT
  } phase_t;

  function automatic logic [15:0] dec16(logic [15:0] acc, logic [3:0] d);
    logic [19:0] v;
    v = 20'(acc) * 20'd10 + 20'(d);
    return (v > 20'h0FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [7:0] dec8(logic [7:0] acc, logic [3:0] d);
    logic [11:0] v;
    v = 12'(acc) * 12'd10 + 12'(d);
    return (v > 12'h0FF) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [3:0] level_of(logic [7:0] lc);
    logic [3:0] code;
    case (lc)
      CH_LF_LO: code = LVL_FATAL;
      CH_LC:    code = LVL_CRITICAL;
      CH_LE:    code = LVL_ERROR;
      CH_LW:    code = LVL_WARNING;
      CH_LI:    code = LVL_INFO;
      CH_LD:    code = LVL_DEBUG;
      CH_LT:    code = LVL_TRACE;
      CH_LS:    code = LVL_STATUS;
      default:  code = LVL_UNKNOWN;
    endcase
    return code;
  endfunction

  phase_t          phase_r, phase_nxt;
  logic [PB-1:0]   byte_position_r, byte_position_nxt;
  logic [PB-1:0]   line_end_r, line_end_nxt;
  logic [PB-1:0]   message_begin_r, message_begin_nxt;
  logic [PB-1:0]   component_begin_r, component_begin_nxt;
  logic [PB-1:0]   component_size_r, component_size_nxt;
  logic [15:0]     year_r, year_nxt;
  logic [7:0]      month_r, month_nxt;
  logic [7:0]      day_r, day_nxt;
  logic [7:0]      hour_r, hour_nxt;
  logic [7:0]      minute_r, minute_nxt;
  logic [7:0]      second_r, second_nxt;
  logic [3:0]      level_r, level_nxt;
  logic [63:0]     thread_r, thread_nxt;
  logic            just_ended_r, just_ended_nxt;

  logic [7:0]      c;
  logic [7:0]      lc;
  logic            is_digit;
  logic            is_hex_letter;
  logic            is_newline;
  logic [3:0]      dv;
  logic [PB-1:0]   msg_len;
  logic [PB-1:0]   cont_len;
  llfp_out_t       msg_rec;
  llfp_out_t       cont_rec;

  assign c             = item.text_byte;
  assign lc            = c | CH_CASE;
  assign is_digit      = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_hex_letter = (lc >= CH_LA) && (lc <= CH_LF_LO);
  assign is_newline    = (c == CH_LF) || (c == CH_CR);
  assign dv            = c[3:0];
  assign msg_len       = byte_position_r - message_begin_r;
  assign cont_len      = byte_position_r - line_end_r;

  always_comb begin
    msg_rec                  = '0;
    msg_rec.level            = level_r;
    msg_rec.year             = year_r;
    msg_rec.month            = month_r;
    msg_rec.day              = day_r;
    msg_rec.hour             = hour_r;
    msg_rec.minute           = minute_r;
    msg_rec.second           = second_r;
    msg_rec.thread_id        = thread_r;
    msg_rec.component_start  = 32'(component_begin_r);
    msg_rec.component_length = 32'(component_size_r);
    msg_rec.text_start       = 32'(message_begin_r);
    msg_rec.text_length      = 32'(msg_len);

    cont_rec             = '0;
    cont_rec.level       = LVL_CONT;
    cont_rec.text_start  = 32'(line_end_r);
    cont_rec.text_length = 32'(cont_len);
  end

  always_comb begin
    phase_nxt           = phase_r;
    byte_position_nxt   = byte_position_r;
    line_end_nxt        = line_end_r;
    message_begin_nxt   = message_begin_r;
    component_begin_nxt = component_begin_r;
    component_size_nxt  = component_size_r;
    year_nxt            = year_r;
    month_nxt           = month_r;
    day_nxt             = day_r;
    hour_nxt            = hour_r;
    minute_nxt          = minute_r;
    second_nxt          = second_r;
    level_nxt           = level_r;
    thread_nxt          = thread_r;
    just_ended_nxt      = just_ended_r;
    rec_valid           = 1'b0;
    rec                 = (phase_r == PH_MESSAGE) ? msg_rec : cont_rec;

    if (item.end_of_data) begin
      // flush the open line, then return to the reset state
      rec_valid           = (phase_r == PH_MESSAGE) || (phase_r == PH_CONT);
      phase_nxt           = PH_YEAR;
      byte_position_nxt   = '0;
      line_end_nxt        = '0;
      message_begin_nxt   = '0;
      component_begin_nxt = '0;
      component_size_nxt  = '0;
      year_nxt            = '0;
      month_nxt           = '0;
      day_nxt             = '0;
      hour_nxt            = '0;
      minute_nxt          = '0;
      second_nxt          = '0;
      level_nxt           = LVL_UNKNOWN;
      thread_nxt          = '0;
      just_ended_nxt      = 1'b1;
    end else begin
      byte_position_nxt = byte_position_r + 1'b1;
      if (is_newline) begin
        if (just_ended_r) begin
          just_ended_nxt = 1'b0;
        end else begin
          rec_valid      = 1'b1;
          line_end_nxt   = byte_position_r;
          year_nxt       = '0;
          month_nxt      = '0;
          day_nxt        = '0;
          hour_nxt       = '0;
          minute_nxt     = '0;
          second_nxt     = '0;
          thread_nxt     = '0;
          phase_nxt      = PH_YEAR;
          just_ended_nxt = 1'b1;
        end
      end else begin
        just_ended_nxt = 1'b0;
        case (phase_r)
          PH_YEAR: begin
            if (is_digit) year_nxt = dec16(year_r, dv);
            else phase_nxt = (c == CH_DASH) ? PH_MONTH : PH_CONT;
          end
          PH_MONTH: begin
            if (is_digit) month_nxt = dec8(month_r, dv);
            else phase_nxt = PH_DAY;
          end
          PH_DAY: begin
            if (is_digit) day_nxt = dec8(day_r, dv);
            else phase_nxt = PH_HOUR;
          end
          PH_HOUR: begin
            if (is_digit) hour_nxt = dec8(hour_r, dv);
            else phase_nxt = PH_MINUTE;
          end
          PH_MINUTE: begin
            if (is_digit) minute_nxt = dec8(minute_r, dv);
            else phase_nxt = PH_SECOND;
          end
          PH_SECOND: begin
            if (is_digit) second_nxt = dec8(second_r, dv);
            else phase_nxt = PH_LEVEL;
          end
          PH_LEVEL: begin
            level_nxt = level_of(lc);
            phase_nxt = PH_LEVEL_SKIP;
          end
          PH_LEVEL_SKIP: begin
            if (c == CH_SPACE) begin
              component_begin_nxt = byte_position_r + 1'b1;
              phase_nxt           = PH_COMPONENT;
            end
          end
          PH_COMPONENT: begin
            if (c == CH_SPACE) begin
              component_size_nxt = byte_position_r - component_begin_r;
              phase_nxt          = PH_COMPONENT_SKIP;
            end
          end
          PH_COMPONENT_SKIP: begin
            if (c == CH_SPACE) phase_nxt = PH_THREAD;
          end
          PH_THREAD: begin
            if (c == CH_SPACE) begin
              message_begin_nxt = byte_position_r + 1'b1;
              phase_nxt         = PH_MESSAGE;
            end else if (is_digit) begin
              thread_nxt = {thread_r[59:0], dv};
            end else if (is_hex_letter) begin
              thread_nxt = {thread_r[59:0], 4'(lc - CH_LA + 8'd10)};
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_YEAR;
      byte_position_r   <= '0;
      line_end_r        <= '0;
      message_begin_r   <= '0;
      component_begin_r <= '0;
      component_size_r  <= '0;
      year_r            <= '0;
      month_r           <= '0;
      day_r             <= '0;
      hour_r            <= '0;
      minute_r          <= '0;
      second_r          <= '0;
      level_r           <= LVL_UNKNOWN;
      thread_r          <= '0;
      just_ended_r      <= 1'b1;
    end else if (advance) begin
      phase_r           <= phase_nxt;
      byte_position_r   <= byte_position_nxt;
      line_end_r        <= line_end_nxt;
      message_begin_r   <= message_begin_nxt;
      component_begin_r <= component_begin_nxt;
      component_size_r  <= component_size_nxt;
      year_r            <= year_nxt;
      month_r           <= month_nxt;
      day_r             <= day_nxt;
      hour_r            <= hour_nxt;
      minute_r          <= minute_nxt;
      second_r          <= second_nxt;
      level_r           <= level_nxt;
      thread_r          <= thread_nxt;
      just_ended_r      <= just_ended_nxt;
    end
  end

`ifndef SYNTHESIS
  a_eod_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.end_of_data |=>
      (byte_position_r == '0) && (phase_r == PH_YEAR) && just_ended_r)
    else $error("end of data did not restart the parser");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(byte_position_r) && $stable(phase_r) && $stable(thread_r))
    else $error("parse state moved without an item");

  a_msg_only_in_message: assert property (@(posedge clk) disable iff (!rst_n)
    advance && rec_valid && (rec.level != LVL_CONT) |-> (phase_r == PH_MESSAGE))
    else $error("message record outside the message phase");
`endif

endmodule

### sv/llfp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llfp_out_reg
// Result register that holds a record until the receiver takes it.
// ----------------------------------------------------------------------------
module llfp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  llfp_pkg::llfp_out_t din,
  output logic                slot_free,
  output logic                out_valid,
  input  logic                out_ready,
  output llfp_pkg::llfp_out_t out_item
);
  import llfp_pkg::*;

  logic      valid_r;
  llfp_out_t data_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

endmodule

### bench/tb_log_line_field_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log_line_field_parser
// Self-checking bench for the log line field parser. Text bytes and
// end-of-data markers go in over the input handshake. A line-record predictor
// tracks the parse phase, byte position and field accumulators, and queues the
// record each item should produce. Every record taken from the output is
// compared field by field against the oldest queued one. Stimulus is a short
// hand-written line set, then random log lines (mostly well formed, some
// truncated, some raw noise) under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------

package llfp_tb_pkg;
  import llfp_pkg::*;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [3:0] {
    LP_YEAR, LP_MONTH, LP_DAY, LP_HOUR, LP_MINUTE, LP_SECOND, LP_LEVEL,
    LP_LEVEL_TAIL, LP_COMPONENT, LP_COMPONENT_TAIL, LP_THREAD, LP_MESSAGE,
    LP_CONT
  } line_phase_t;

  class line_record_scoreboard;
    line_phase_t phase;
    logic [31:0] pos, eol_pos, msg_pos, comp_pos, comp_len;
    logic [15:0] yr;
    logic [7:0]  mo, dy, hr, mi, se;
    logic [3:0]  lvl;
    logic [63:0] tid;
    bit          after_eol;
    llfp_out_t   pending_records[$];
    int unsigned mismatches;
    int unsigned records_checked;

    function new();
      mismatches      = 0;
      records_checked = 0;
      reset_state();
    endfunction

    function void clear_fields();
      yr    = '0;
      mo    = '0;
      dy    = '0;
      hr    = '0;
      mi    = '0;
      se    = '0;
      tid   = '0;
      phase = LP_YEAR;
    endfunction

    function void reset_state();
      clear_fields();
      pos       = '0;
      eol_pos   = '0;
      msg_pos   = '0;
      comp_pos  = '0;
      comp_len  = '0;
      lvl       = LVL_UNKNOWN;
      after_eol = 1'b1;
    endfunction

    function int unsigned fold_decimal(int unsigned acc, int unsigned d, int unsigned limit);
      int unsigned v;
      v = acc * 10 + d;
      return (v > limit) ? limit : v;
    endfunction

    function llfp_out_t message_record(logic [31:0] end_pos);
      llfp_out_t r;
      r.level            = lvl;
      r.year             = yr;
      r.month            = mo;
      r.day              = dy;
      r.hour             = hr;
      r.minute           = mi;
      r.second           = se;
      r.thread_id        = tid;
      r.component_start  = comp_pos;
      r.component_length = comp_len;
      r.text_start       = msg_pos;
      r.text_length      = end_pos - msg_pos;
      return r;
    endfunction

    function llfp_out_t cont_record(logic [31:0] end_pos);
      llfp_out_t r;
      r             = '0;
      r.level       = LVL_CONT;
      r.text_start  = eol_pos;
      r.text_length = end_pos - eol_pos;
      return r;
    endfunction

    // Advance the line state by one accepted item; queue the record it causes.
    function void note_item(llfp_in_t item);
      logic [7:0]  c, lc;
      logic [31:0] here;
      logic        is_digit;
      logic [3:0]  dv, nib;
      c        = item.text_byte;
      lc       = c | CASE_BIT;
      here     = pos;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      dv       = is_digit ? 4'(c - CH_ZERO) : 4'd0;

      if (item.end_of_data) begin
        if (phase == LP_MESSAGE)
          pending_records.push_back(message_record(here));
        else if (phase == LP_CONT)
          pending_records.push_back(cont_record(here));
        reset_state();
        return;
      end

      pos = here + 32'd1;

      if (c == CH_LF || c == CH_CR) begin
        if (after_eol) begin
          after_eol = 1'b0;
          return;
        end
        if (phase == LP_MESSAGE)
          pending_records.push_back(message_record(here));
        else
          pending_records.push_back(cont_record(here));
        eol_pos = here;
        clear_fields();
        after_eol = 1'b1;
        return;
      end
      after_eol = 1'b0;

      case (phase)
        LP_YEAR: begin
          if (is_digit) yr = 16'(fold_decimal(32'(yr), 32'(dv), 32'hFFFF));
          else phase = (c == CH_DASH) ? LP_MONTH : LP_CONT;
        end
        LP_MONTH: begin
          if (is_digit) mo = 8'(fold_decimal(32'(mo), 32'(dv), 32'hFF));
          else phase = LP_DAY;
        end
        LP_DAY: begin
          if (is_digit) dy = 8'(fold_decimal(32'(dy), 32'(dv), 32'hFF));
          else phase = LP_HOUR;
        end
        LP_HOUR: begin
          if (is_digit) hr = 8'(fold_decimal(32'(hr), 32'(dv), 32'hFF));
          else phase = LP_MINUTE;
        end
        LP_MINUTE: begin
          if (is_digit) mi = 8'(fold_decimal(32'(mi), 32'(dv), 32'hFF));
          else phase = LP_SECOND;
        end
        LP_SECOND: begin
          if (is_digit) se = 8'(fold_decimal(32'(se), 32'(dv), 32'hFF));
          else phase = LP_LEVEL;
        end
        LP_LEVEL: begin
          case (lc)
            "f":     lvl = LVL_FATAL;
            "c":     lvl = LVL_CRITICAL;
            "e":     lvl = LVL_ERROR;
            "w":     lvl = LVL_WARNING;
            "i":     lvl = LVL_INFO;
            "d":     lvl = LVL_DEBUG;
            "t":     lvl = LVL_TRACE;
            "s":     lvl = LVL_STATUS;
            default: lvl = LVL_UNKNOWN;
          endcase
          phase = LP_LEVEL_TAIL;
        end
        LP_LEVEL_TAIL: begin
          if (c == CH_SPACE) begin
            comp_pos = here + 32'd1;
            phase    = LP_COMPONENT;
          end
        end
        LP_COMPONENT: begin
          if (c == CH_SPACE) begin
            comp_len = here - comp_pos;
            phase    = LP_COMPONENT_TAIL;
          end
        end
        LP_COMPONENT_TAIL: begin
          if (c == CH_SPACE) phase = LP_THREAD;
        end
        LP_THREAD: begin
          if (c == CH_SPACE) begin
            msg_pos = here + 32'd1;
            phase   = LP_MESSAGE;
          end else if (is_digit || (lc >= CH_LOW_A && lc <= CH_LOW_F)) begin
            nib = is_digit ? dv : 4'(lc - CH_LOW_A + 8'd10);
            tid = {tid[59:0], nib};
          end
        end
        default: ;
      endcase
    endfunction

    function string record_text(llfp_out_t r);
      return $sformatf("lvl=%0d date=%0d-%0d-%0d %0d:%0d:%0d tid=%h comp=%0d/%0d text=%0d/%0d",
                       r.level, r.year, r.month, r.day, r.hour, r.minute, r.second,
                       r.thread_id, r.component_start, r.component_length,
                       r.text_start, r.text_length);
    endfunction

    function void check_record(llfp_out_t got);
      llfp_out_t want;
      records_checked++;
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] record with nothing queued: %s", $time, record_text(got));
        return;
      end
      want = pending_records.pop_front();
      if (got.level !== want.level || got.year !== want.year ||
          got.month !== want.month || got.day !== want.day ||
          got.hour !== want.hour || got.minute !== want.minute ||
          got.second !== want.second || got.thread_id !== want.thread_id ||
          got.component_start !== want.component_start ||
          got.component_length !== want.component_length ||
          got.text_start !== want.text_start ||
          got.text_length !== want.text_length) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] record mismatch", $time);
          $display("  expected %s", record_text(want));
          $display("  actual   %s", record_text(got));
        end
      end
    endfunction
  endclass

endpackage

module tb_log_line_field_parser;
  import llfp_pkg::*;
  import llfp_tb_pkg::*;

  // Cycles with no item moving on either side before the run is called hung.
  localparam int unsigned QUIET_LIMIT   = 4000;
  // Per random phase: keep sending whole lines until this many items went in.
  localparam int unsigned PHASE_ITEMS   = 200;
  // Cycles to hold after the last record, so a stray late record is caught.
  localparam int unsigned SETTLE_CYCLES = 20;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  llfp_in_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  llfp_out_t out_item;

  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;

  // Bytes of the line being sent, and whether an end-of-data item follows it.
  logic [7:0] line_bytes[$];
  bit         eod_after;
  logic [7:0] level_letters[8] = '{"f", "c", "e", "w", "i", "d", "t", "s"};

  line_record_scoreboard records;

  log_line_field_parser DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: drop ready on a random share of cycles set by the phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor and watchdog. Sample both handshakes as they stood before the edge;
  // note inputs first so a record can never overtake its own item.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) records.note_item(in_item);
    if (rst_n && out_valid && out_ready) records.check_record(out_item);
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item and hold it until accepted. With the sender idling,
  // drop valid first for a random run of cycles.
  task automatic send_item(input llfp_in_t item);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item('{text_byte: s[i], end_of_data: 1'b0});
  endtask

  task automatic send_end_of_data();
    send_item('{text_byte: 8'($urandom_range(255)), end_of_data: 1'b1});
  endtask

  // Release valid and wait until every queued record has come back.
  task automatic drain_records();
    in_valid <= 1'b0;
    while (records.pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Any byte but a line end; optionally no space either.
  function automatic logic [7:0] pick_byte(input bit allow_space);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CH_LF || b == CH_CR || (!allow_space && b == CH_SPACE));
    return b;
  endfunction

  // A date or time field terminator: anything but a digit or a line end.
  function automatic logic [7:0] pick_separator();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CH_LF || b == CH_CR || (b >= CH_ZERO && b <= CH_NINE));
    return b;
  endfunction

  function automatic logic [7:0] pick_hex();
    int unsigned n;
    logic [7:0]  b;
    n = $urandom_range(15);
    b = (n < 10) ? 8'(CH_ZERO + n) : 8'(CH_LOW_A + n - 10);
    if (n >= 10 && $urandom_range(1) == 1) b = b & ~CASE_BIT;
    return b;
  endfunction

  function automatic void push_digits(input int unsigned n);
    repeat (n) line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
  endfunction

  function automatic void push_word(input int unsigned n);
    repeat (n) line_bytes.push_back(pick_byte(1'b0));
  endfunction

  // Build one random line. Most follow the date / level / component / thread /
  // message layout with random content; some are cut short or have a bad year
  // terminator, and some are raw byte noise that may hold line ends of its own.
  function automatic void compose_line();
    int unsigned style, n, keep, ending;
    logic [7:0]  b;
    line_bytes.delete();
    eod_after = 1'b0;
    style = $urandom_range(99);
    if (style < 15) begin
      repeat ($urandom_range(8)) line_bytes.push_back(8'($urandom_range(255)));
    end else begin
      // Up to six digits, enough to push the year past its maximum.
      push_digits($urandom_range(6));
      line_bytes.push_back((style < 22) ? pick_separator() : CH_DASH);
      // Three digits can push month..second past their maximum.
      repeat (5) begin
        push_digits($urandom_range(3));
        line_bytes.push_back(pick_separator());
      end
      if ($urandom_range(3) != 0) begin
        b = level_letters[$urandom_range(7)];
        if ($urandom_range(1) == 1) b = b & ~CASE_BIT;
      end else begin
        b = pick_byte(1'b1);
      end
      line_bytes.push_back(b);
      push_word($urandom_range(3));
      line_bytes.push_back(CH_SPACE);
      push_word($urandom_range(5));
      line_bytes.push_back(CH_SPACE);
      push_word($urandom_range(3));
      line_bytes.push_back(CH_SPACE);
      // Long thread ids can wrap the 64-bit accumulator.
      n = ($urandom_range(3) == 0) ? $urandom_range(17, 20) : $urandom_range(6);
      repeat (n) line_bytes.push_back(($urandom_range(4) == 0) ? pick_byte(1'b0) : pick_hex());
      line_bytes.push_back(CH_SPACE);
      repeat ($urandom_range(6)) line_bytes.push_back(pick_byte(1'b1));
      if (style < 30) begin
        keep = $urandom_range(line_bytes.size() - 1);
        while (line_bytes.size() > keep) void'(line_bytes.pop_back());
      end
    end
    ending = $urandom_range(19);
    if (ending == 0) begin
      eod_after = 1'b1;
    end else if (ending < 9) begin
      line_bytes.push_back(CH_LF);
    end else if (ending < 14) begin
      line_bytes.push_back(CH_CR);
    end else begin
      line_bytes.push_back(CH_CR);
      line_bytes.push_back(CH_LF);
    end
    // An extra line end gives an empty line or a skipped one.
    if ($urandom_range(9) == 0) line_bytes.push_back(CH_LF);
    if ($urandom_range(24) == 0) eod_after = 1'b1;
  endfunction

  task automatic run_phase(input int unsigned idle, input int unsigned stall);
    int unsigned first_item;
    idle_pct   = idle;
    stall_pct  = stall;
    first_item = items_sent;
    while (items_sent - first_item < PHASE_ITEMS) begin
      compose_line();
      foreach (line_bytes[i]) send_item('{text_byte: line_bytes[i], end_of_data: 1'b0});
      if (eod_after) send_end_of_data();
    end
    drain_records();
  endtask

  initial begin
    records = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines, no idling.
    send_text("\n");        // line end at the very start: skipped
    send_text("z\r");       // bad year terminator, closed by CR: continuation
    send_text("\n");        // LF right after a line end: skipped
    send_text("\r");        // empty line: continuation
    send_end_of_data();     // end of data at a line start: no record
    send_text("1-2-3 4:5:6 E a  f m");
    send_end_of_data();     // end of data in the message: flush it
    drain_records();

    // Random lines: no idling, sender idle, receiver stalling, both.
    run_phase(0, 0);
    run_phase(79, 0);
    run_phase(0, 79);
    run_phase(18, 18);

    if (records.mismatches == 0 && records.pending_records.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/llfp_pkg.sv
sv/llfp_core.sv
sv/llfp_out_reg.sv
sv/log_line_field_parser.sv
bench/tb_log_line_field_parser.sv
